// ----- rtl/ddo_pkg.sv -----
// Shared widths, fixed-point constants, arctangent table and status struct
// for the differential drive odometry block. No dependencies.
`default_nettype none

package ddo_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ATAN_TABLE_SIZE = 24;
  localparam int CORDIC_ITERS    = (CORDIC_STEPS > ATAN_TABLE_SIZE) ? ATAN_TABLE_SIZE
                                                                    : CORDIC_STEPS;
  localparam int ITER_W          = $clog2(ATAN_TABLE_SIZE);
  localparam int REDUCE_PASSES   = 4;

  // field and register widths
  localparam int ENC_W     = 16;
  localparam int GYRO_W    = 16;
  localparam int OFS_W     = 20;
  localparam int TICK_W    = 20;
  localparam int POS_W     = 32;
  localparam int HEAD_W    = 21;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int SUM_W   = ENC_W + 1;
  localparam int STEP_W  = SUM_W + TICK_W + 1;
  localparam int GPROD_W = GYRO_W + 21;
  localparam int ANGLE_W = HEAD_W + 8;
  localparam int TRIG_W  = 27;

  // digit-serial multiplier
  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = (TRIG_W + DIGIT_W) / DIGIT_W;
  localparam int MUL_W      = MUL_DIGITS * DIGIT_W;
  localparam int DCNT_W     = $clog2(MUL_DIGITS);
  localparam int ACC_W      = STEP_W + DIGIT_W + 1;
  localparam int ROUND_SH   = 41;
  localparam int HI_SH      = ROUND_SH - MUL_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TICK_DISTANCE  = CFG_IDX_W'(1);

  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(366327);

  // pi/18000 in Q32
  localparam logic signed [GPROD_W-1:0] GYRO_TO_RAD_Q32 = GPROD_W'(749613);
  localparam logic signed [ANGLE_W-1:0] TWO_PI_Q24      = ANGLE_W'(105414357);
  localparam logic signed [ANGLE_W-1:0] PI_Q24          = ANGLE_W'(52707179);
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q24     = ANGLE_W'(26353589);
  localparam logic signed [TRIG_W-1:0]  INV_GAIN_Q24    = TRIG_W'(10188014);

  typedef struct packed {
    logic busy;
    logic done;
  } ddo_stat_t;

  function automatic logic signed [ANGLE_W-1:0] atan_q24(input logic [ITER_W-1:0] i);
    logic signed [ANGLE_W-1:0] v;
    case (i)
      5'd0:    v = ANGLE_W'(13176795);
      5'd1:    v = ANGLE_W'(7778716);
      5'd2:    v = ANGLE_W'(4110060);
      5'd3:    v = ANGLE_W'(2086331);
      5'd4:    v = ANGLE_W'(1047214);
      5'd5:    v = ANGLE_W'(524117);
      5'd6:    v = ANGLE_W'(262123);
      5'd7:    v = ANGLE_W'(131069);
      5'd8:    v = ANGLE_W'(65536);
      5'd9:    v = ANGLE_W'(32768);
      5'd10:   v = ANGLE_W'(16384);
      5'd11:   v = ANGLE_W'(8192);
      5'd12:   v = ANGLE_W'(4096);
      5'd13:   v = ANGLE_W'(2048);
      5'd14:   v = ANGLE_W'(1024);
      5'd15:   v = ANGLE_W'(512);
      5'd16:   v = ANGLE_W'(256);
      5'd17:   v = ANGLE_W'(128);
      5'd18:   v = ANGLE_W'(64);
      5'd19:   v = ANGLE_W'(32);
      5'd20:   v = ANGLE_W'(16);
      5'd21:   v = ANGLE_W'(8);
      5'd22:   v = ANGLE_W'(4);
      5'd23:   v = ANGLE_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ddo_ifs.sv -----
// Valid/ready channel interfaces for sensor samples and odometry results.
// Depends on ddo_pkg for field widths.
`default_nettype none

interface ddo_sample_if import ddo_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ENC_W-1:0]         left_encoder;
  logic [ENC_W-1:0]         right_encoder;
  logic signed [GYRO_W-1:0] gyro_angle;

  modport source (output valid, left_encoder, right_encoder, gyro_angle, input ready);
  modport sink   (input valid, left_encoder, right_encoder, gyro_angle, output ready);
endinterface

interface ddo_result_if import ddo_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [HEAD_W-1:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

`default_nettype wire

// ----- rtl/ddo_cordic.sv -----
// Iterative rotation-mode CORDIC: range reduction, quadrant fold, then one
// micro-rotation per cycle. Depends on ddo_pkg.
`default_nettype none

module ddo_cordic import ddo_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic signed [ANGLE_W-1:0] angle,
  output ddo_stat_t                      stat,
  output logic signed [TRIG_W-1:0]       cos_q,
  output logic signed [TRIG_W-1:0]       sin_q
);

  typedef enum logic [2:0] {C_IDLE, C_REDUCE, C_FOLD, C_ITER, C_FIN} cstate_t;

  cstate_t                   state;
  logic [ITER_W-1:0]         cnt;
  logic                      done;
  logic                      neg;
  logic signed [ANGLE_W-1:0] a;
  logic signed [TRIG_W-1:0]  x;
  logic signed [TRIG_W-1:0]  y;
  logic signed [TRIG_W-1:0]  xs;
  logic signed [TRIG_W-1:0]  ys;
  logic signed [ANGLE_W-1:0] at;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = atan_q24(cnt);

  assign stat.busy = (state != C_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == C_FIN);
      case (state)
        C_IDLE: begin
          if (start) begin
            a     <= angle;
            cnt   <= '0;
            state <= C_REDUCE;
          end
        end
        C_REDUCE: begin
          if (a > PI_Q24) begin
            a <= a - TWO_PI_Q24;
          end else if (a < -PI_Q24) begin
            a <= a + TWO_PI_Q24;
          end
          if (cnt == ITER_W'(REDUCE_PASSES - 1)) begin
            cnt   <= '0;
            state <= C_FOLD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        C_FOLD: begin
          neg <= 1'b0;
          if (a > HALF_PI_Q24) begin
            a   <= a - PI_Q24;
            neg <= 1'b1;
          end else if (a < -HALF_PI_Q24) begin
            a   <= a + PI_Q24;
            neg <= 1'b1;
          end
          x     <= INV_GAIN_Q24;
          y     <= '0;
          cnt   <= '0;
          state <= C_ITER;
        end
        C_ITER: begin
          if (a >= 0) begin
            x <= x - ys;
            y <= y + xs;
            a <= a - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            a <= a + at;
          end
          if (cnt == ITER_W'(CORDIC_ITERS - 1)) begin
            state <= C_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        C_FIN: begin
          cos_q <= neg ? -x : x;
          sin_q <= neg ? -y : y;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ddo_serial_mul.sv -----
// Two-lane digit-serial multiplier: step length times cosine and sine, one
// 4-bit digit of the trig value per cycle, rounded to position units.
// Depends on ddo_pkg.
`default_nettype none

module ddo_serial_mul import ddo_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [STEP_W-1:0] step,
  input  wire logic signed [TRIG_W-1:0] cos_q,
  input  wire logic signed [TRIG_W-1:0] sin_q,
  output ddo_stat_t                     stat,
  output logic signed [POS_W-1:0]       dx,
  output logic signed [POS_W-1:0]       dy
);

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'd1 << (HI_SH - 1));

  logic                      busy;
  logic                      done;
  logic [DCNT_W-1:0]         cnt;
  logic                      last;
  logic [MUL_W-1:0]          m   [2];
  logic signed [ACC_W-1:0]   hi  [2];
  logic signed [DIGIT_W:0]   dig [2];
  logic signed [ACC_W-1:0]   sum [2];
  logic signed [ACC_W-1:0]   rnd [2];

  assign last = (cnt == DCNT_W'(MUL_DIGITS - 1));

  // the top digit carries the sign weight
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dig[l] = last ? {m[l][DIGIT_W-1], m[l][DIGIT_W-1:0]} : {1'b0, m[l][DIGIT_W-1:0]};
      sum[l] = hi[l] + ACC_W'(step) * ACC_W'(dig[l]);
      rnd[l] = (sum[l] >>> DIGIT_W) + RND;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (!busy) begin
      done <= 1'b0;
      if (start) begin
        m[0]  <= MUL_W'(cos_q);
        m[1]  <= MUL_W'(sin_q);
        hi[0] <= '0;
        hi[1] <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end
    end else begin
      done <= last;
      for (int l = 0; l < 2; l++) begin
        hi[l] <= sum[l] >>> DIGIT_W;
        m[l]  <= m[l] >> DIGIT_W;
      end
      cnt <= cnt + 1'b1;
      if (last) begin
        // low product bits never reach the rounding bit, so only hi matters
        dx   <= POS_W'(rnd[0] >>> HI_SH);
        dy   <= POS_W'(rnd[1] >>> HI_SH);
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/differential_drive_odometry.sv -----
// Differential drive odometry with gyro heading: sequencer, front end, position
// accumulators. Depends on ddo_pkg, ddo_ifs, ddo_cordic, ddo_serial_mul.
// A sample passes through the product and heading registers, the CORDIC (one rotation
// per cycle) and the 7-digit serial multiply before its result is valid. One sample
// in flight; the next is taken in the cycle after the result is registered. Sync
// reset clears counts and position, loads register defaults.

`default_nettype none

module differential_drive_odometry import ddo_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  ddo_sample_if.sink                sample,
  ddo_result_if.source              result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_PROD, ST_HEAD, ST_CORDIC, ST_MUL, ST_OUT} state_t;

  state_t                     state;
  logic signed [OFS_W-1:0]    heading_offset;
  logic [TICK_W-1:0]          tick_distance;
  logic [ENC_W-1:0]           last_left_count;
  logic [ENC_W-1:0]           last_right_count;
  logic [POS_W-1:0]           x_accum;
  logic [POS_W-1:0]           y_accum;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [GYRO_W-1:0]   gyro_r;
  logic signed [STEP_W-1:0]   step;
  logic signed [GPROD_W-1:0]  gprod;
  logic signed [HEAD_W-1:0]   head;
  logic                       cordic_go;
  logic                       mul_go;

  logic signed [ENC_W-1:0]    dl;
  logic signed [ENC_W-1:0]    dr;
  logic signed [SUM_W-1:0]    sum_next;
  logic signed [GPROD_W-1:0]  g_rnd;
  logic signed [HEAD_W:0]     head_wide;
  logic [POS_W-1:0]           x_next;
  logic [POS_W-1:0]           y_next;
  logic                       load_out;

  ddo_stat_t                  cstat;
  ddo_stat_t                  mstat;
  logic signed [TRIG_W-1:0]   cos_q;
  logic signed [TRIG_W-1:0]   sin_q;
  logic signed [POS_W-1:0]    dx;
  logic signed [POS_W-1:0]    dy;

  // wrapped count changes, read as signed
  assign dl        = $signed(sample.left_encoder - last_left_count);
  assign dr        = $signed(sample.right_encoder - last_right_count);
  assign sum_next  = SUM_W'(dl) + SUM_W'(dr);
  assign g_rnd     = gprod + GPROD_W'(64'd1 << 15);
  assign head_wide = (HEAD_W + 1)'(g_rnd >>> 16) - (HEAD_W + 1)'(heading_offset);
  assign x_next    = x_accum + POS_W'(dx);
  assign y_next    = y_accum + POS_W'(dy);
  assign load_out  = (state == ST_OUT) && (!result.valid || result.ready);

  assign sample.ready = (state == ST_IDLE);

  ddo_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_go),
    .angle ({head, 8'b0}),
    .stat  (cstat),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  ddo_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .step  (step),
    .cos_q (cos_q),
    .sin_q (sin_q),
    .stat  (mstat),
    .dx    (dx),
    .dy    (dy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_offset <= '0;
      tick_distance  <= TICK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADING_OFFSET: heading_offset <= $signed(cfg_data[OFS_W-1:0]);
        REG_TICK_DISTANCE:  tick_distance  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      last_left_count  <= '0;
      last_right_count <= '0;
      x_accum          <= '0;
      y_accum          <= '0;
      result.valid     <= 1'b0;
      cordic_go        <= 1'b0;
      mul_go           <= 1'b0;
    end else begin
      cordic_go <= (state == ST_HEAD);
      mul_go    <= (state == ST_CORDIC) && cstat.done;
      if (result.valid && result.ready && !load_out) begin
        result.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            sum_r            <= sum_next;
            gyro_r           <= sample.gyro_angle;
            last_left_count  <= sample.left_encoder;
            last_right_count <= sample.right_encoder;
            state            <= ST_PROD;
          end
        end
        ST_PROD: begin
          step  <= STEP_W'(sum_r) * STEP_W'($signed({1'b0, tick_distance}));
          gprod <= GPROD_W'(gyro_r) * GYRO_TO_RAD_Q32;
          state <= ST_HEAD;
        end
        ST_HEAD: begin
          head  <= head_wide[HEAD_W-1:0];
          state <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (cstat.done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mstat.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load_out) begin
            x_accum        <= x_next;
            y_accum        <= y_next;
            result.pos_x   <= $signed(x_next);
            result.pos_y   <= $signed(y_next);
            result.heading <= head;
            result.valid   <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cordic_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    cstat.done |-> state == ST_CORDIC)
    else $error("cordic finished outside its wait state");

  a_mul_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    mstat.done |-> state == ST_MUL)
    else $error("multiplier finished outside its wait state");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cstat.busy && mstat.busy))
    else $error("cordic and multiplier busy together");

  a_accum_only_on_load: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && x_accum != $past(x_accum)) |-> $past(state) == ST_OUT)
    else $error("x position changed outside result load");

endmodule

`default_nettype wire
